>>> hdl/c_line_code_scanner_top_assert.svh
// ----------------------------------------------------------------------------
// c_line_code_scanner_top_assert.svh
// assertion macros for the c line code scanner
// ----------------------------------------------------------------------------
`ifndef C_LINE_CODE_SCANNER_TOP_ASSERT_SVH
`define C_LINE_CODE_SCANNER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// clocked check, off while reset is applied
`define CLCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define CLCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CLCS_ASSERT(lbl, prop, msg)
`define CLCS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hdl/clcs_pkg.sv
// ----------------------------------------------------------------------------
// clcs_pkg
// shared types and constants of the c line code scanner
// ----------------------------------------------------------------------------
package clcs_pkg;

    localparam int MAX_LINE   = 1024;
    localparam int POS_W      = $clog2(MAX_LINE + 1);
    localparam int IDX_W      = $clog2(MAX_LINE);
    localparam int DEPTH_W    = $clog2(MAX_LINE + 1);
    localparam int CODE_END_W = 11;
    localparam int PAREN_W    = 12;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    typedef enum logic [3:0] {
        MODE_NORMAL,
        MODE_SLASH,
        MODE_BLOCK,
        MODE_BLOCK_STAR,
        MODE_LINE,
        MODE_SQ,
        MODE_SQ_ESC,
        MODE_DQ,
        MODE_DQ_ESC
    } lex_mode_t;

    typedef enum logic [1:0] {
        BRACE_NONE,
        BRACE_OPEN,
        BRACE_CLOSE
    } brace_kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } item_t;

    typedef struct packed {
        logic signed [CODE_END_W-1:0] code_end_index;
        logic                         ends_statement;
        logic                         ends_with_open_brace;
        logic                         unmatched_close_brace;
        logic signed [PAREN_W-1:0]    paren_balance;
    } result_t;

endpackage

>>> hdl/clcs_if.sv
// ----------------------------------------------------------------------------
// clcs_in_if / clcs_out_if
// valid/ready channels for characters in and line reports out
// ----------------------------------------------------------------------------
interface clcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;

    modport source (output valid, output ch, output line_end, input ready);
    modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface clcs_out_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [clcs_pkg::CODE_END_W-1:0]      code_end_index;
    logic                                        ends_statement;
    logic                                        ends_with_open_brace;
    logic                                        unmatched_close_brace;
    logic signed [clcs_pkg::PAREN_W-1:0]         paren_balance;

    modport source (
        output valid, output code_end_index, output ends_statement,
        output ends_with_open_brace, output unmatched_close_brace,
        output paren_balance, input ready
    );
    modport sink (
        input valid, input code_end_index, input ends_statement,
        input ends_with_open_brace, input unmatched_close_brace,
        input paren_balance, output ready
    );
endinterface

>>> hdl/clcs_in_reg.sv
// ----------------------------------------------------------------------------
// clcs_in_reg
// input register: holds one character transfer until the lexer takes it
// ----------------------------------------------------------------------------
module clcs_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    clcs_in_if.sink          stream,
    input  logic             consume,
    output logic             valid,
    output clcs_pkg::item_t  item
);

    logic            valid_reg;
    logic            valid_next;
    clcs_pkg::item_t item_reg;
    logic            take;

    // the slot frees up in the same cycle the lexer consumes it
    assign stream.ready = !valid_reg || consume;
    assign take         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.ch       <= stream.ch;
            item_reg.line_end <= stream.line_end;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

>>> hdl/clcs_lexer.sv
// ----------------------------------------------------------------------------
// clcs_lexer
// lexical state of the current line, one character per cycle unless a terminator waits for the result register
// ----------------------------------------------------------------------------
module clcs_lexer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  clcs_pkg::item_t    item,
    input  logic               out_free,
    output logic               fire,
    output logic               res_valid,
    output clcs_pkg::result_t  res
);

    localparam logic signed [clcs_pkg::PAREN_W-1:0] PAREN_MAX =
        clcs_pkg::PAREN_W'(clcs_pkg::MAX_LINE);
    localparam logic signed [clcs_pkg::PAREN_W-1:0] PAREN_MIN = -PAREN_MAX;
    localparam logic [clcs_pkg::POS_W-1:0] POS_MAX =
        clcs_pkg::POS_W'(clcs_pkg::MAX_LINE);
    localparam logic [clcs_pkg::POS_W-1:0] IDX_LAST_POS =
        clcs_pkg::POS_W'(clcs_pkg::MAX_LINE - 1);
    localparam logic [clcs_pkg::DEPTH_W-1:0] DEPTH_MAX =
        clcs_pkg::DEPTH_W'(clcs_pkg::MAX_LINE);

    clcs_pkg::lex_mode_t                   mode_reg, mode_next;
    logic [clcs_pkg::POS_W-1:0]            pos_reg, pos_next;
    logic [clcs_pkg::CODE_END_W-1:0]       cutoff_reg, cutoff_next;
    logic [7:0]                            last_vis_reg, last_vis_next;
    logic [7:0]                            vis_slash_reg, vis_slash_next;
    logic [7:0]                            vis_comment_reg, vis_comment_next;
    logic signed [clcs_pkg::PAREN_W-1:0]   paren_reg, paren_next;
    logic [clcs_pkg::DEPTH_W-1:0]          depth_reg, depth_next;
    clcs_pkg::brace_kind_t                 brace_reg, brace_next;
    logic                                  close_zero_reg, close_zero_next;

    logic [7:0]                            c;
    logic [clcs_pkg::IDX_W-1:0]            idx;
    logic                                  code_char;
    logic                                  is_space;
    logic [clcs_pkg::CODE_END_W-1:0]       end_idx;
    logic [7:0]                            end_vis;

    // a terminator waits while the output register is still full
    assign fire      = item_valid && (!item.line_end || out_free);
    assign res_valid = fire && item.line_end;
    assign c         = item.ch;

    assign idx = (pos_reg >= IDX_LAST_POS) ? IDX_LAST_POS[clcs_pkg::IDX_W-1:0]
                                           : pos_reg[clcs_pkg::IDX_W-1:0];

    always_comb
    begin
        is_space = (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D});
    end

    // report of the line, from the state before the terminator
    always_comb
    begin
        case (mode_reg)
            clcs_pkg::MODE_LINE, clcs_pkg::MODE_BLOCK, clcs_pkg::MODE_BLOCK_STAR:
            begin
                end_idx = cutoff_reg;
                end_vis = vis_comment_reg;
            end
            clcs_pkg::MODE_SQ, clcs_pkg::MODE_SQ_ESC,
            clcs_pkg::MODE_DQ, clcs_pkg::MODE_DQ_ESC:
            begin
                end_idx = cutoff_reg;
                end_vis = 8'h00;
            end
            default:
            begin
                end_idx = clcs_pkg::CODE_END_W'(pos_reg) - clcs_pkg::CODE_END_W'(1);
                end_vis = last_vis_reg;
            end
        endcase
        res.code_end_index        = $signed(end_idx);
        res.ends_statement        = !end_idx[clcs_pkg::CODE_END_W-1] &&
                                    ((end_vis == clcs_pkg::CH_RBRACE) ||
                                     (end_vis == clcs_pkg::CH_SEMI));
        res.ends_with_open_brace  = (brace_reg == clcs_pkg::BRACE_OPEN);
        res.unmatched_close_brace = close_zero_reg;
        res.paren_balance         = paren_reg;
    end

    always_comb
    begin
        mode_next        = mode_reg;
        pos_next         = pos_reg;
        cutoff_next      = cutoff_reg;
        last_vis_next    = last_vis_reg;
        vis_slash_next   = vis_slash_reg;
        vis_comment_next = vis_comment_reg;
        paren_next       = paren_reg;
        depth_next       = depth_reg;
        brace_next       = brace_reg;
        close_zero_next  = close_zero_reg;
        code_char        = 1'b0;

        if (fire && item.line_end)
        begin
            mode_next        = clcs_pkg::MODE_NORMAL;
            pos_next         = '0;
            cutoff_next      = '1;
            last_vis_next    = 8'h00;
            vis_slash_next   = 8'h00;
            vis_comment_next = 8'h00;
            paren_next       = '0;
            depth_next       = '0;
            brace_next       = clcs_pkg::BRACE_NONE;
            close_zero_next  = 1'b0;
        end
        else if (fire)
        begin
            case (mode_reg)
                clcs_pkg::MODE_NORMAL:
                begin
                    code_char = 1'b1;
                end
                clcs_pkg::MODE_SLASH:
                begin
                    if (c == clcs_pkg::CH_SLASH)
                    begin
                        vis_comment_next = vis_slash_reg;
                        mode_next        = clcs_pkg::MODE_LINE;
                    end
                    else if (c == clcs_pkg::CH_STAR)
                    begin
                        vis_comment_next = vis_slash_reg;
                        mode_next        = clcs_pkg::MODE_BLOCK;
                    end
                    else
                    begin
                        // lone slash, this character is code again
                        mode_next = clcs_pkg::MODE_NORMAL;
                        code_char = 1'b1;
                    end
                end
                clcs_pkg::MODE_BLOCK:
                begin
                    if (c == clcs_pkg::CH_STAR)
                    begin
                        mode_next = clcs_pkg::MODE_BLOCK_STAR;
                    end
                end
                clcs_pkg::MODE_BLOCK_STAR:
                begin
                    if (c == clcs_pkg::CH_SLASH)
                    begin
                        mode_next = clcs_pkg::MODE_NORMAL;
                    end
                    else if (c != clcs_pkg::CH_STAR)
                    begin
                        mode_next = clcs_pkg::MODE_BLOCK;
                    end
                end
                clcs_pkg::MODE_SQ:
                begin
                    if (c == clcs_pkg::CH_BSLASH)
                    begin
                        mode_next = clcs_pkg::MODE_SQ_ESC;
                    end
                    else if (c == clcs_pkg::CH_SQUOTE)
                    begin
                        mode_next = clcs_pkg::MODE_NORMAL;
                    end
                end
                clcs_pkg::MODE_SQ_ESC:
                begin
                    mode_next = clcs_pkg::MODE_SQ;
                end
                clcs_pkg::MODE_DQ:
                begin
                    if (c == clcs_pkg::CH_BSLASH)
                    begin
                        mode_next = clcs_pkg::MODE_DQ_ESC;
                    end
                    else if (c == clcs_pkg::CH_DQUOTE)
                    begin
                        mode_next = clcs_pkg::MODE_NORMAL;
                    end
                end
                clcs_pkg::MODE_DQ_ESC:
                begin
                    mode_next = clcs_pkg::MODE_DQ;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase

            if (code_char)
            begin
                case (c)
                    clcs_pkg::CH_SLASH:
                    begin
                        vis_slash_next = last_vis_reg;
                        cutoff_next    = clcs_pkg::CODE_END_W'(idx) -
                                         clcs_pkg::CODE_END_W'(1);
                        mode_next      = clcs_pkg::MODE_SLASH;
                    end
                    clcs_pkg::CH_SQUOTE:
                    begin
                        cutoff_next = clcs_pkg::CODE_END_W'(idx);
                        mode_next   = clcs_pkg::MODE_SQ;
                    end
                    clcs_pkg::CH_DQUOTE:
                    begin
                        cutoff_next = clcs_pkg::CODE_END_W'(idx);
                        mode_next   = clcs_pkg::MODE_DQ;
                    end
                    clcs_pkg::CH_LBRACE:
                    begin
                        if (depth_reg != DEPTH_MAX)
                        begin
                            depth_next = depth_reg + clcs_pkg::DEPTH_W'(1);
                        end
                        brace_next = clcs_pkg::BRACE_OPEN;
                    end
                    clcs_pkg::CH_RBRACE:
                    begin
                        // depth stays at zero, the flag is sticky
                        if (depth_reg == '0)
                        begin
                            close_zero_next = 1'b1;
                        end
                        else
                        begin
                            depth_next = depth_reg - clcs_pkg::DEPTH_W'(1);
                        end
                        brace_next = clcs_pkg::BRACE_CLOSE;
                    end
                    clcs_pkg::CH_LPAREN:
                    begin
                        if (paren_reg < PAREN_MAX)
                        begin
                            paren_next = paren_reg + clcs_pkg::PAREN_W'(1);
                        end
                    end
                    clcs_pkg::CH_RPAREN:
                    begin
                        if (paren_reg > PAREN_MIN)
                        begin
                            paren_next = paren_reg - clcs_pkg::PAREN_W'(1);
                        end
                    end
                    default:
                    begin
                        paren_next = paren_reg;
                    end
                endcase
            end

            if (!is_space)
            begin
                last_vis_next = c;
            end
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + clcs_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= clcs_pkg::MODE_NORMAL;
            pos_reg         <= '0;
            cutoff_reg      <= '1;
            last_vis_reg    <= 8'h00;
            vis_slash_reg   <= 8'h00;
            vis_comment_reg <= 8'h00;
            paren_reg       <= '0;
            depth_reg       <= '0;
            brace_reg       <= clcs_pkg::BRACE_NONE;
            close_zero_reg  <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            pos_reg         <= pos_next;
            cutoff_reg      <= cutoff_next;
            last_vis_reg    <= last_vis_next;
            vis_slash_reg   <= vis_slash_next;
            vis_comment_reg <= vis_comment_next;
            paren_reg       <= paren_next;
            depth_reg       <= depth_next;
            brace_reg       <= brace_next;
            close_zero_reg  <= close_zero_next;
        end
    end

endmodule

>>> hdl/clcs_out_reg.sv
// ----------------------------------------------------------------------------
// clcs_out_reg
// result register: holds one line report until the sink takes it
// ----------------------------------------------------------------------------
module clcs_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  clcs_pkg::result_t  res,
    output logic               free,
    clcs_out_if.source         report
);

    logic              valid_reg;
    logic              valid_next;
    clcs_pkg::result_t res_reg;

    assign free = !valid_reg || report.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign report.valid                 = valid_reg;
    assign report.code_end_index        = res_reg.code_end_index;
    assign report.ends_statement        = res_reg.ends_statement;
    assign report.ends_with_open_brace  = res_reg.ends_with_open_brace;
    assign report.unmatched_close_brace = res_reg.unmatched_close_brace;
    assign report.paren_balance         = res_reg.paren_balance;

endmodule

>>> hdl/c_line_code_scanner_top.sv
// ----------------------------------------------------------------------------
// c_line_code_scanner_top
// scans a c source line one character per transfer and reports its shape
// ----------------------------------------------------------------------------
//  channel  dir  modport  payload
//  stream   in   sink     ch, line_end
//  report   out  source   code_end_index, ends_statement, ends_with_open_brace,
//                         unmatched_close_brace, paren_balance
//
// one character per cycle: input register, lexer state update, result register
// a line report comes from the result register, loaded as its terminator fires
// rst_n clears the lexer state and both valid flags at once, no clearing pass
// a terminator waits in the input register while report holds an untaken result;
// characters keep flowing as long as no terminator is stalled
// ----------------------------------------------------------------------------
`include "c_line_code_scanner_top_assert.svh"

module c_line_code_scanner_top (
    input  logic        clk,
    input  logic        rst_n,
    clcs_in_if.sink     stream,
    clcs_out_if.source  report
);

    logic              in_valid;
    clcs_pkg::item_t   in_item;
    logic              lex_fire;
    logic              lex_res_valid;
    clcs_pkg::result_t lex_res;
    logic              out_free;

    clcs_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream),
        .consume (lex_fire),
        .valid   (in_valid),
        .item    (in_item)
    );

    clcs_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid),
        .item       (in_item),
        .out_free   (out_free),
        .fire       (lex_fire),
        .res_valid  (lex_res_valid),
        .res        (lex_res)
    );

    clcs_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (lex_res_valid),
        .res    (lex_res),
        .free   (out_free),
        .report (report)
    );

    // a report only comes from a terminator transfer through the lexer
    `CLCS_ASSERT(a_report_from_term, $rose(report.valid) |-> $past(lex_res_valid), "report without terminator")
    // a result never overwrites one that the sink has not taken
    `CLCS_ASSERT_ALWAYS(a_no_overwrite, lex_res_valid |-> (!report.valid || report.ready), "result overwritten")
    // a held character is not dropped before the lexer takes it
    `CLCS_ASSERT(a_item_kept, (in_valid && !lex_fire) |=> in_valid, "input item lost")

endmodule

>>> tb/sv/clcs_line_checker.sv
// ----------------------------------------------------------------------------
// clcs_line_checker
// watches both channels of the c line code scanner, predicts every line
// report from the accepted characters and compares it field by field
// ----------------------------------------------------------------------------
module clcs_line_checker (
    input  logic clk,
    input  logic rst_n,
    clcs_in_if   stream,
    clcs_out_if  report,
    output int   errors,
    output int   pending,
    output int   reports_checked
);
    import clcs_pkg::*;

    // lexer state of the line being scanned
    lex_mode_t   mode;
    int          pos;
    int          cut;
    logic [7:0]  last_vis;
    logic [7:0]  vis_slash;
    logic [7:0]  vis_open;
    int          paren;
    int          depth;
    brace_kind_t brace;
    logic        close_zero;

    result_t     line_reports_q[$];

    function automatic bit is_blank(logic [7:0] c);
        // space, tab, newline, vertical tab, form feed, carriage return
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void clear_line();
        mode       = MODE_NORMAL;
        pos        = 0;
        cut        = -1;
        last_vis   = 8'h00;
        vis_slash  = 8'h00;
        vis_open   = 8'h00;
        paren      = 0;
        depth      = 0;
        brace      = BRACE_NONE;
        close_zero = 1'b0;
    endfunction

    function automatic void code_char(logic [7:0] c, int idx);
        case (c)
            CH_SLASH:
            begin
                vis_slash = last_vis;
                cut       = idx - 1;
                mode      = MODE_SLASH;
            end
            CH_SQUOTE:
            begin
                cut  = idx;
                mode = MODE_SQ;
            end
            CH_DQUOTE:
            begin
                cut  = idx;
                mode = MODE_DQ;
            end
            CH_LBRACE:
            begin
                if (depth < MAX_LINE)
                    depth++;
                brace = BRACE_OPEN;
            end
            CH_RBRACE:
            begin
                if (depth == 0)
                    close_zero = 1'b1;
                else
                    depth--;
                brace = BRACE_CLOSE;
            end
            CH_LPAREN:
            begin
                if (paren < MAX_LINE)
                    paren++;
            end
            CH_RPAREN:
            begin
                if (paren > -MAX_LINE)
                    paren--;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void take_char(logic [7:0] c);
        int idx;
        idx = (pos < MAX_LINE - 1) ? pos : MAX_LINE - 1;
        case (mode)
            MODE_NORMAL:
                code_char(c, idx);
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    vis_open = vis_slash;
                    mode     = MODE_LINE;
                end
                else if (c == CH_STAR)
                begin
                    vis_open = vis_slash;
                    mode     = MODE_BLOCK;
                end
                else
                begin
                    // lone slash, the character after it is plain code
                    mode = MODE_NORMAL;
                    code_char(c, idx);
                end
            end
            MODE_BLOCK:
            begin
                if (c == CH_STAR)
                    mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR:
            begin
                if (c == CH_SLASH)
                    mode = MODE_NORMAL;
                else if (c != CH_STAR)
                    mode = MODE_BLOCK;
            end
            MODE_SQ:
            begin
                if (c == CH_BSLASH)
                    mode = MODE_SQ_ESC;
                else if (c == CH_SQUOTE)
                    mode = MODE_NORMAL;
            end
            MODE_SQ_ESC:
                mode = MODE_SQ;
            MODE_DQ:
            begin
                if (c == CH_BSLASH)
                    mode = MODE_DQ_ESC;
                else if (c == CH_DQUOTE)
                    mode = MODE_NORMAL;
            end
            MODE_DQ_ESC:
                mode = MODE_DQ;
            default:
            begin
            end
        endcase
        if (!is_blank(c))
            last_vis = c;
        if (pos < MAX_LINE)
            pos++;
    endfunction

    function automatic void close_line();
        int         stop_idx;
        logic [7:0] vis;
        result_t    r;
        case (mode)
            MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR:
            begin
                stop_idx = cut;
                vis      = vis_open;
            end
            MODE_SQ, MODE_SQ_ESC, MODE_DQ, MODE_DQ_ESC:
            begin
                // open literal, code ends at its opening quote, which never ends a statement
                stop_idx = cut;
                vis      = 8'h00;
            end
            default:
            begin
                stop_idx = pos - 1;
                vis      = last_vis;
            end
        endcase
        r.code_end_index        = stop_idx[CODE_END_W-1:0];
        r.ends_statement        = (stop_idx >= 0) && (vis == CH_RBRACE || vis == CH_SEMI);
        r.ends_with_open_brace  = (brace == BRACE_OPEN);
        r.unmatched_close_brace = close_zero;
        r.paren_balance         = paren[PAREN_W-1:0];
        line_reports_q.push_back(r);
        clear_line();
    endfunction

    function automatic void check_field(string name, logic signed [15:0] want,
                                        logic signed [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_line();
            line_reports_q.delete();
            errors          = 0;
            reports_checked = 0;
        end
        else
        begin
            if (report.valid && report.ready)
            begin
                if (line_reports_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: report with no line pending, expected none, actual %0d",
                             $time, report.code_end_index);
                end
                else
                begin
                    want = line_reports_q.pop_front();
                    reports_checked++;
                    check_field("code_end_index", $signed(want.code_end_index),
                                $signed(report.code_end_index));
                    check_field("ends_statement", want.ends_statement,
                                report.ends_statement);
                    check_field("ends_with_open_brace", want.ends_with_open_brace,
                                report.ends_with_open_brace);
                    check_field("unmatched_close_brace", want.unmatched_close_brace,
                                report.unmatched_close_brace);
                    check_field("paren_balance", $signed(want.paren_balance),
                                $signed(report.paren_balance));
                end
            end
            if (stream.valid && stream.ready)
            begin
                if (stream.line_end)
                    close_line();
                else
                    take_char(stream.ch);
            end
        end
        pending = line_reports_q.size();
    end

endmodule

>>> tb/sv/c_line_code_scanner_top_tb.sv
// ----------------------------------------------------------------------------
// c_line_code_scanner_top_tb
// drives short c-like lines, noise and a saturating long line into the
// scanner with random stalls on both sides; a checker predicts every report
// ----------------------------------------------------------------------------
module c_line_code_scanner_top_tb;
    import clcs_pkg::*;

    localparam int TOTAL_ITEMS  = 1750;
    localparam int CALM_AFTER   = 1500;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    clcs_in_if  stream ();
    clcs_out_if report ();

    int errors;
    int pending;
    int reports_checked;

    c_line_code_scanner_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .report (report)
    );

    clcs_line_checker line_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .stream          (stream),
        .report          (report),
        .errors          (errors),
        .pending         (pending),
        .reports_checked (reports_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    int cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports still pending", cycles, pending);
            $display("FAIL");
            $finish;
        end
    end

    // pacing knobs for the sender and the receiver
    bit calm        = 1'b0;
    bit src_idle_on = 1'b1;
    bit rcv_idle_on = 1'b1;
    int hold_ticket = 0;
    int hold_served = 0;

    logic [7:0] line_q[$];
    int         chars_sent = 0;
    int         lines_sent = 0;
    int         items_sent = 0;

    logic [7:0] blanks[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    task automatic send_xfer(input logic [7:0] c, input logic le);
        if (!calm && src_idle_on && $urandom_range(0, 6) == 0)
        begin
            stream.valid    <= 1'b0;
            stream.ch       <= 8'($urandom);
            stream.line_end <= 1'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        stream.valid    <= 1'b1;
        stream.ch       <= c;
        stream.line_end <= le;
        @(posedge clk);
        while (!stream.ready)
            @(posedge clk);
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_xfer(line_q[i], 1'b0);
        // terminator carries a random byte that must be ignored
        send_xfer(8'($urandom), 1'b1);
        chars_sent += line_q.size();
        items_sent += line_q.size() + 1;
        lines_sent++;
        line_q.delete();
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    task automatic push_range(int n, int lo, int hi);
        repeat (n)
            line_q.push_back(8'($urandom_range(hi, lo)));
    endtask

    task automatic push_literal(logic [7:0] quote);
        int n;
        n = $urandom_range(0, 5);
        line_q.push_back(quote);
        repeat (n)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                line_q.push_back(CH_BSLASH);
                push_range(1, 0, 255);
            end
            else if ($urandom_range(0, 1) == 0)
                push_range(1, 0, 255);
            else
                push_range(1, 8'h61, 8'h7A);
        end
        case ($urandom_range(0, 5))
            0:
            begin
            end
            1:
                line_q.push_back(CH_BSLASH);
            default:
                line_q.push_back(quote);
        endcase
    endtask

    task automatic add_token();
        int n;
        n = $urandom_range(1, 5);
        case ($urandom_range(0, 19))
            0, 1, 2, 3:
                push_range(n, 8'h61, 8'h7A);
            4:
                repeat (n) line_q.push_back(blanks[$urandom_range(0, 5)]);
            5:
                line_q.push_back(CH_LBRACE);
            6:
                line_q.push_back(CH_RBRACE);
            7:
                line_q.push_back(CH_LPAREN);
            8:
                line_q.push_back(CH_RPAREN);
            9:
                line_q.push_back(CH_SEMI);
            10:
            begin
                push_str("//");
                push_range(n, 0, 255);
            end
            11:
            begin
                push_str("/*");
                push_range(n, 0, 255);
                if ($urandom_range(0, 1) == 0)
                    line_q.push_back(CH_STAR);
                push_str("*/");
            end
            12:
            begin
                push_str("/*");
                push_range(n, 8'h20, 8'h7E);
            end
            13:
                push_literal(CH_DQUOTE);
            14:
                push_literal(CH_SQUOTE);
            15:
                line_q.push_back(CH_SLASH);
            16:
                push_range(1, 0, 255);
            17:
                line_q.push_back(8'h00);
            18:
                push_range(1, 128, 255);
            default:
                line_q.push_back(CH_STAR);
        endcase
    endtask

    // receiver: short random stalls, one long hold-off when asked
    initial
    begin
        report.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != hold_served)
            begin
                hold_served++;
                report.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                report.ready <= 1'b1;
            end
            else if (!calm && rcv_idle_on && $urandom_range(0, 4) == 0)
            begin
                report.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                report.ready <= 1'b1;
            end
            else
                report.ready <= 1'b1;
        end
    end

    initial
    begin
        int line_no;
        int tokens;
        stream.valid    <= 1'b0;
        stream.ch       <= 8'h00;
        stream.line_end <= 1'b0;
        rst_n           <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines
        send_line();                        // empty line
        push_str("x}//");
        send_line();                        // line comment after a stray close brace
        push_str("{(/*;");
        send_line();                        // open block comment
        push_str("(\"\\");
        send_line();                        // escape right before the terminator
        push_str("a/b/");
        send_line();                        // lone slash, slash at end of line
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        push_str(");");
        send_line();
        push_str("'*/';\t");
        send_line();                        // closed char literal, trailing blank

        // paren balance, character count and index all saturate
        repeat (MAX_LINE + 1) line_q.push_back(CH_LPAREN);
        push_str("//");
        send_line();

        line_no = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (line_no % 25 == 0)
            begin
                src_idle_on = $urandom_range(0, 2) != 0;
                rcv_idle_on = $urandom_range(0, 2) != 0;
            end
            if (line_no == 5)
                hold_ticket++;
            calm = items_sent >= CALM_AFTER;
            if ($urandom_range(0, 9) == 0)
                push_range($urandom_range(0, 20), 0, 255);
            else
            begin
                tokens = $urandom_range(0, 10);
                repeat (tokens) add_token();
                case ($urandom_range(0, 11))
                    0:
                        line_q.push_back(CH_SLASH);
                    1:
                    begin
                        line_q.push_back(CH_DQUOTE);
                        line_q.push_back(CH_BSLASH);
                    end
                    default:
                    begin
                    end
                endcase
            end
            send_line();
            line_no++;
        end
        stream.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("scanned %0d lines with %0d characters, %0d reports checked", lines_sent,
                 chars_sent, reports_checked);
        $display("covered open comments and literals, a saturating line and a %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/clcs_pkg.sv
hdl/clcs_if.sv
hdl/clcs_in_reg.sv
hdl/clcs_lexer.sv
hdl/clcs_out_reg.sv
hdl/c_line_code_scanner_top.sv
tb/sv/clcs_line_checker.sv
tb/sv/c_line_code_scanner_top_tb.sv
